@@ sv/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ sv/ttia_pkg.sv @@
// types and constants of the typed tagged integer alu
package ttia_pkg;
    localparam int unsigned WORD_WIDTH = 32;
    localparam int unsigned OUT_WIDTH  = 32;

    typedef enum logic [2:0] {
        K_AND = 3'd0, K_OR = 3'd1, K_XOR = 3'd2, K_MUL = 3'd3,
        K_DIV = 3'd4, K_MOD = 3'd5, K_ADD = 3'd6, K_SUB = 3'd7
    } t_kind;

    localparam logic [1:0] TAG_U       = 2'd0;
    localparam logic [1:0] TAG_S       = 2'd1;
    localparam logic [1:0] TAG_UNKNOWN = 2'd2;

    typedef struct packed {
        logic       vld;
        logic [2:0] kind;
        logic       ls;
        logic       rs;
        logic       err;
        logic       zero;
        logic       qneg;
        logic       rneg;
        logic [1:0] tag;
    } t_ctl;
endpackage

@@ sv/ttia_cell.sv @@
// one restoring divider step cell, registered
module ttia_cell #(
    parameter int unsigned W = ttia_pkg::WORD_WIDTH,
    parameter int unsigned IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  ttia_pkg::t_ctl  i_ctl,
    input  logic [W-1:0]    i_rem,
    input  logic [W-1:0]    i_quo,
    input  logic [W-1:0]    i_dvs,
    input  logic [W-1:0]    i_res,
    output ttia_pkg::t_ctl  o_ctl,
    output logic [W-1:0]    o_rem,
    output logic [W-1:0]    o_quo,
    output logic [W-1:0]    o_dvs,
    output logic [W-1:0]    o_res
);
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic [W-1:0] n_rem, n_quo;
    ttia_pkg::t_ctl r_ctl;
    logic [W-1:0] r_rem, r_quo, r_dvs, r_res;

    always_comb begin
        trial = {i_rem, i_quo[W-1-IDX]};
        diff  = trial - {1'b0, i_dvs};
        n_quo = i_quo;
        if (!diff[W]) begin
            n_rem = diff[W-1:0];
            n_quo[W-1-IDX] = 1'b1;
        end else begin
            n_rem = trial[W-1:0];
            n_quo[W-1-IDX] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_dvs <= i_dvs;
            r_res <= i_res;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_dvs = r_dvs;
    assign o_res = r_res;
endmodule

@@ sv/ttia_front.sv @@
// operand decode, bitwise, add, sub and multiply, registered
module ttia_front #(
    parameter int unsigned W = ttia_pkg::WORD_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [2:0]      i_kind,
    input  logic [1:0]      i_lhs_type,
    input  logic [W-1:0]    i_a,
    input  logic [1:0]      i_rhs_type,
    input  logic [W-1:0]    i_b,
    output ttia_pkg::t_ctl  o_ctl,
    output logic [W-1:0]    o_dvd,
    output logic [W-1:0]    o_dvs,
    output logic [W-1:0]    o_res
);
    logic ls, rs, any_s, an, bn, sdiv_mode;
    logic [W-1:0] sum, dif, prod, n_res, ma, mb;
    logic [1:0] n_tag;
    ttia_pkg::t_ctl n_ctl, r_ctl;
    logic [W-1:0] r_dvd, r_dvs, r_res;
    logic [2*W-1:0] full;

    always_comb begin
        ls = (i_lhs_type == ttia_pkg::TAG_S);
        rs = (i_rhs_type == ttia_pkg::TAG_S);
        any_s = ls | rs;
        an = i_a[W-1];
        bn = i_b[W-1];
        sum = i_a + i_b;
        dif = i_a - i_b;
        full = i_a * i_b;
        prod = full[W-1:0];
        sdiv_mode = any_s;
        ma = (sdiv_mode && an) ? (~i_a + 1'b1) : i_a;
        mb = (sdiv_mode && bn) ? (~i_b + 1'b1) : i_b;
        n_res = '0;
        n_tag = ttia_pkg::TAG_U;
        case (ttia_pkg::t_kind'(i_kind))
            ttia_pkg::K_AND: n_res = i_a & i_b;
            ttia_pkg::K_OR:  n_res = i_a | i_b;
            ttia_pkg::K_XOR: n_res = i_a ^ i_b;
            ttia_pkg::K_MUL: begin
                n_res = prod;
                if (ls && rs) n_tag = prod[W-1] ? ttia_pkg::TAG_S : ttia_pkg::TAG_U;
                else n_tag = any_s ? ttia_pkg::TAG_S : ttia_pkg::TAG_U;
            end
            ttia_pkg::K_ADD: begin
                n_res = sum;
                if (!any_s) n_tag = ttia_pkg::TAG_U;
                else if (ls && rs) n_tag = {1'b0, sum[W-1]};
                else if (rs) n_tag = (!bn || an) ? ttia_pkg::TAG_U : {1'b0, sum[W-1]};
                else n_tag = (!an || bn) ? ttia_pkg::TAG_U : {1'b0, sum[W-1]};
            end
            ttia_pkg::K_SUB: begin
                n_res = dif;
                if (!any_s) n_tag = (i_a >= i_b) ? ttia_pkg::TAG_U : ttia_pkg::TAG_S;
                else if (ls && rs)
                    n_tag = (!an && i_a != '0 && bn) ? ttia_pkg::TAG_U
                                                     : {1'b0, dif[W-1]};
                else if (rs) n_tag = bn ? ttia_pkg::TAG_U : {1'b0, dif[W-1]};
                else n_tag = bn ? ttia_pkg::TAG_S : {1'b0, dif[W-1]};
            end
            default: begin
                n_res = '0;
                n_tag = ttia_pkg::TAG_U;
            end
        endcase
        n_ctl.vld  = i_vld;
        n_ctl.kind = i_kind;
        n_ctl.ls   = ls;
        n_ctl.rs   = rs;
        n_ctl.err  = i_lhs_type[1] | i_rhs_type[1];
        n_ctl.zero = (i_b == '0);
        n_ctl.qneg = sdiv_mode & (an ^ bn);
        n_ctl.rneg = sdiv_mode & an;
        n_ctl.tag  = n_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
        if (i_en) begin
            r_dvd <= ma;
            r_dvs <= mb;
            r_res <= n_res;
        end
    end

    assign o_ctl = r_ctl;
    assign o_dvd = r_dvd;
    assign o_dvs = r_dvs;
    assign o_res = r_res;
endmodule

@@ sv/typed_tagged_integer_alu.sv @@
// top level of the typed tagged integer alu
// usage: one input channel (i_valid/o_ready) carries kind, both operand
// tags and both operand values; one output channel (o_valid/i_ready)
// carries result_value, result_type and syntax_error.
// every beat passes a front stage (decode, logic ops, add, sub, multiply)
// and then a chain of WORD_WIDTH divider cells, one quotient bit each,
// then a fixup stage that signs the quotient or remainder and picks
// the result into the output register. throughput is one beat per cycle
// while the receiver takes results: all stages advance together.
// when the receiver stalls the whole chain holds: o_ready drops whenever
// the output register is full and not taken, even if slots further up
// the chain are empty, and every beat in flight waits in place.
// reset clears all valid flags; no result is pending after reset.
module typed_tagged_integer_alu #(
    parameter int unsigned WORD_WIDTH = ttia_pkg::WORD_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_kind,
    input  logic [1:0]            i_lhs_type,
    input  logic [31:0]           i_lhs_value,
    input  logic [1:0]            i_rhs_type,
    input  logic [31:0]           i_rhs_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [31:0]           o_result_value,
    output logic [1:0]            o_result_type,
    output logic                  o_syntax_error
);
    localparam int unsigned W = WORD_WIDTH;

    logic en;
    ttia_pkg::t_ctl ctl [W+1];
    logic [W-1:0] rem [W+1];
    logic [W-1:0] quo [W+1];
    logic [W-1:0] dvs [W+1];
    logic [W-1:0] res [W+1];
    logic [W-1:0] a_w, b_w;
    logic [W-1:0] q, r, n_val;
    logic [1:0] n_tag;
    logic r_valid;
    logic [W-1:0] r_val;
    logic [1:0] r_tag;
    logic r_err;
    ttia_pkg::t_ctl lc;

    assign en = !r_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        a_w = '0;
        b_w = '0;
        if (W >= 32) begin
            a_w[31:0] = i_lhs_value;
            b_w[31:0] = i_rhs_value;
        end else begin
            a_w = i_lhs_value[W-1:0];
            b_w = i_rhs_value[W-1:0];
        end
    end

    ttia_front #(.W(W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_valid),
        .i_kind(i_kind), .i_lhs_type(i_lhs_type), .i_a(a_w),
        .i_rhs_type(i_rhs_type), .i_b(b_w),
        .o_ctl(ctl[0]), .o_dvd(quo[0]), .o_dvs(dvs[0]), .o_res(res[0])
    );
    assign rem[0] = '0;

    for (genvar g = 0; g < W; g++) begin : g_cell
        ttia_cell #(.W(W), .IDX(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(ctl[g]), .i_rem(rem[g]), .i_quo(quo[g]),
            .i_dvs(dvs[g]), .i_res(res[g]),
            .o_ctl(ctl[g+1]), .o_rem(rem[g+1]), .o_quo(quo[g+1]),
            .o_dvs(dvs[g+1]), .o_res(res[g+1])
        );
    end

    always_comb begin
        lc = ctl[W];
        q = lc.qneg ? (~quo[W] + 1'b1) : quo[W];
        r = lc.rneg ? (~rem[W] + 1'b1) : rem[W];
        n_val = res[W];
        n_tag = lc.tag;
        if (lc.kind == ttia_pkg::K_DIV || lc.kind == ttia_pkg::K_MOD) begin
            n_val = (lc.kind == ttia_pkg::K_DIV) ? q : r;
            if (lc.zero) begin
                n_val = '0;
                n_tag = ttia_pkg::TAG_UNKNOWN;
            end else if (!(lc.ls || lc.rs)) begin
                n_tag = ttia_pkg::TAG_U;
            end else if (lc.ls && lc.rs) begin
                n_tag = {1'b0, n_val[W-1]};
            end else begin
                n_tag = ttia_pkg::TAG_S;
            end
        end
        if (lc.err) begin
            n_val = '0;
            n_tag = ttia_pkg::TAG_U;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= lc.vld;
        end
        if (en) begin
            r_val <= n_val;
            r_tag <= n_tag;
            r_err <= lc.err;
        end
    end

    assign o_valid = r_valid;
    assign o_syntax_error = r_err;
    assign o_result_type = r_tag;
    always_comb begin
        o_result_value = '0;
        if (W >= 32) o_result_value = r_val[31:0];
        else o_result_value[W-1:0] = r_val;
    end

`include "assert_macros.svh"
    `ASSERT_IMPL(a_stall_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_result_value)))
    `ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, (o_valid && o_syntax_error) |-> (o_result_value == '0 && o_result_type == ttia_pkg::TAG_U))
    `ASSERT_NEVER(a_bad_tag, i_clk, i_rst_n, o_valid && o_result_type == 2'd3)
endmodule

@@ bench/typed_tagged_integer_alu_check.sv @@
// checker: predicts each result of the typed tagged integer alu and compares it with the output beats
`timescale 1ns / 100ps
module typed_tagged_integer_alu_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [2:0]  i_kind,
    input  logic [1:0]  i_lhs_type,
    input  logic [31:0] i_lhs_value,
    input  logic [1:0]  i_rhs_type,
    input  logic [31:0] i_rhs_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_result_value,
    input  logic [1:0]  i_result_type,
    input  logic        i_syntax_error,
    input  logic        i_final,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  tag;
        logic        err;
    } t_answer;

    t_answer answers[$];

    function automatic logic [1:0] sign_tag(logic [31:0] v);
        return v[31] ? ttia_pkg::TAG_S : ttia_pkg::TAG_U;
    endfunction

    function automatic logic [31:0] mag(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic t_answer evaluate(logic [2:0] k, logic [1:0] lt, logic [31:0] a,
                                         logic [1:0] rt, logic [31:0] b);
        t_answer r;
        logic ls;
        logic rs;
        logic [31:0] q;
        r = '0;
        ls = (lt == ttia_pkg::TAG_S);
        rs = (rt == ttia_pkg::TAG_S);
        if (lt > ttia_pkg::TAG_S || rt > ttia_pkg::TAG_S) begin
            r.err = 1'b1;
            return r;
        end
        case (ttia_pkg::t_kind'(k))
            ttia_pkg::K_AND: r.value = a & b;
            ttia_pkg::K_OR:  r.value = a | b;
            ttia_pkg::K_XOR: r.value = a ^ b;
            ttia_pkg::K_MUL: begin
                r.value = a * b;
                r.tag = (ls && rs) ? sign_tag(r.value)
                                   : ((ls || rs) ? ttia_pkg::TAG_S : ttia_pkg::TAG_U);
            end
            ttia_pkg::K_DIV, ttia_pkg::K_MOD: begin
                if (b == 0) begin
                    r.tag = ttia_pkg::TAG_UNKNOWN;
                end else if (!ls && !rs) begin
                    r.value = (ttia_pkg::t_kind'(k) == ttia_pkg::K_DIV) ? a / b : a % b;
                end else begin
                    if (ttia_pkg::t_kind'(k) == ttia_pkg::K_DIV) begin
                        q = mag(a) / mag(b);
                        r.value = (a[31] != b[31]) ? -q : q;
                    end else begin
                        q = mag(a) % mag(b);
                        r.value = a[31] ? -q : q;
                    end
                    r.tag = (ls && rs) ? sign_tag(r.value) : ttia_pkg::TAG_S;
                end
            end
            ttia_pkg::K_ADD: begin
                r.value = a + b;
                if (ls && rs) r.tag = sign_tag(r.value);
                else if (rs) r.tag = (!b[31] || a[31]) ? ttia_pkg::TAG_U : sign_tag(r.value);
                else if (ls) r.tag = (!a[31] || b[31]) ? ttia_pkg::TAG_U : sign_tag(r.value);
            end
            default: begin
                r.value = a - b;
                if (!ls && !rs) r.tag = (a >= b) ? ttia_pkg::TAG_U : ttia_pkg::TAG_S;
                else if (ls && rs)
                    r.tag = (!a[31] && a != 0 && b[31]) ? ttia_pkg::TAG_U : sign_tag(r.value);
                else if (rs) r.tag = b[31] ? ttia_pkg::TAG_U : sign_tag(r.value);
                else r.tag = b[31] ? ttia_pkg::TAG_S : sign_tag(r.value);
            end
        endcase
        return r;
    endfunction

    initial begin
        o_errors = 0;
        o_results = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_answer want;
        int bad;
        bad = 0;
        if (i_rst_n && i_valid && i_ready_in)
            answers.push_back(evaluate(i_kind, i_lhs_type, i_lhs_value, i_rhs_type, i_rhs_value));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            o_results <= o_results + 1;
            if (answers.size() == 0) begin
                $error("result beat with nothing expected");
                bad++;
            end else begin
                want = answers.pop_front();
                if (i_result_value !== want.value) begin
                    $error("result_value expected %h got %h", want.value, i_result_value);
                    bad++;
                end
                if (i_result_type !== want.tag) begin
                    $error("result_type expected %0d got %0d", want.tag, i_result_type);
                    bad++;
                end
                if (i_syntax_error !== want.err) begin
                    $error("syntax_error expected %0d got %0d", want.err, i_syntax_error);
                    bad++;
                end
            end
        end
        o_errors <= o_errors + bad;
        o_pending <= answers.size();
    end

    always @(posedge i_final) begin
        if (answers.size() != 0) begin
            $error("%0d results never arrived", answers.size());
            o_errors <= o_errors + 1;
        end
    end
endmodule

@@ bench/typed_tagged_integer_alu_test.sv @@
// testbench top: drives operations into the typed tagged integer alu and reports the verdict
`timescale 1ns / 100ps
module typed_tagged_integer_alu_test;
    localparam int LATENCY = ttia_pkg::WORD_WIDTH + 2;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_kind = '0;
    logic [1:0]  i_lhs_type = '0;
    logic [31:0] i_lhs_value = '0;
    logic [1:0]  i_rhs_type = '0;
    logic [31:0] i_rhs_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_result_value;
    logic [1:0]  o_result_type;
    logic        o_syntax_error;
    logic        done = 1'b0;
    logic        hold_sink = 1'b0;
    logic        start_hold = 1'b0;
    logic        calm = 1'b0;
    int          errors;
    int          pending;
    int          results;

    typed_tagged_integer_alu dut (.*);

    typed_tagged_integer_alu_check checker_inst (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_kind, .i_lhs_type,
        .i_lhs_value, .i_rhs_type, .i_rhs_value, .i_out_valid(o_valid),
        .i_out_ready(i_ready), .i_result_value(o_result_value),
        .i_result_type(o_result_type), .i_syntax_error(o_syntax_error),
        .i_final(done), .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // sink side
    always @(negedge i_clk) begin
        if (hold_sink) i_ready <= 1'b0;
        else if (calm) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(99) >= 32);
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(9);
            5: return -$urandom_range(9);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(logic [2:0] k, logic [1:0] lt, logic [31:0] a,
                        logic [1:0] rt, logic [31:0] b);
        i_valid <= 1'b1;
        i_kind <= k;
        i_lhs_type <= lt;
        i_lhs_value <= a;
        i_rhs_type <= rt;
        i_rhs_value <= b;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic [1:0] lt;
        logic [1:0] rt;
        lt = ($urandom_range(15) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
        rt = ($urandom_range(15) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
        if (!calm && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        send(3'($urandom_range(7)), lt, pick_value(), rt, pick_value());
    endtask

    initial begin
        int waited;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: every op over a signed pair and random tags with edge operands
        for (int k = 0; k < 8; k++) begin
            send(3'(k), ttia_pkg::TAG_S, 32'h8000_0000, ttia_pkg::TAG_S, 32'hffff_ffff);
            send(3'(k), 2'($urandom_range(1)), 32'hffff_ffff, 2'($urandom_range(1)), 32'h0);
        end
        send(ttia_pkg::K_MOD, ttia_pkg::TAG_S, 32'hffff_fff9, ttia_pkg::TAG_U, 32'd3);
        send(ttia_pkg::K_MOD, ttia_pkg::TAG_U, 32'd7, ttia_pkg::TAG_S, 32'hffff_fffe);
        send(ttia_pkg::K_DIV, ttia_pkg::TAG_U, 32'hffff_ffff, ttia_pkg::TAG_U, 32'd7);
        send(ttia_pkg::K_ADD, 2'd2, 32'd1, ttia_pkg::TAG_U, 32'd1);
        send(ttia_pkg::K_SUB, ttia_pkg::TAG_S, 32'd1, 2'd3, 32'd1);
        send(ttia_pkg::K_SUB, ttia_pkg::TAG_U, 32'd1, ttia_pkg::TAG_U, 32'd2);
        send(ttia_pkg::K_ADD, ttia_pkg::TAG_U, 32'h8000_0000, ttia_pkg::TAG_S, 32'hffff_ffff);
        // receiver holds off while items keep coming
        start_hold <= 1'b1;
        repeat (60) send_random();
        repeat (300) send_random();
        // sender pauses until everything has drained
        i_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(negedge i_clk);
            waited++;
        end
        calm <= 1'b1;
        repeat (100) send_random();
        calm <= 1'b0;
        repeat (140) send_random();
        i_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (2 * LATENCY) @(negedge i_clk);
        done <= 1'b1;
        @(negedge i_clk);
        $display("ran %0d results over all ops, tag pairs and edge operands,", results);
        $display("with source gaps, sink stalls and a long sink hold-off");
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    // long receiver hold-off counted in cycles
    initial begin
        wait (start_hold);
        @(negedge i_clk);
        hold_sink <= 1'b1;
        repeat (80) @(negedge i_clk);
        hold_sink <= 1'b0;
    end
endmodule
